@@ hdl/rfbs_pkg.sv @@
// rfbs_pkg: shared constants, codes and types of the fifo bank scheduler
// used by every file of the block; depends on nothing

package rfbs_pkg;

  localparam int NUM_FIFOS  = 16;
  localparam int FIFO_DEPTH = 64;

  // field widths of the request and result
  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int PKT_W    = 32;
  localparam int STAT_W   = 2;
  localparam int TOTAL_W  = 11;
  localparam int COUNT_W  = 32;

  // internal widths
  localparam int Q_W      = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
  localparam int HEAD_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int OCC_W    = $clog2(FIFO_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_FIFOS * FIFO_DEPTH;
  localparam int ADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SETPTR = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage

@@ hdl/rfbs_req_if.sv @@
// rfbs_req_if: request channel of the fifo bank scheduler
// depends on rfbs_pkg for field widths

interface rfbs_req_if;
  logic                          valid;
  logic                          ready;
  logic [rfbs_pkg::OP_W-1:0]     opcode;
  logic [rfbs_pkg::IDX_W-1:0]    fifo_index;
  logic [rfbs_pkg::PKT_W-1:0]    packet_handle;

  modport source (output valid, opcode, fifo_index, packet_handle, input ready);
  modport sink (input valid, opcode, fifo_index, packet_handle, output ready);
endinterface

@@ hdl/rfbs_rsp_if.sv @@
// rfbs_rsp_if: result channel of the fifo bank scheduler
// depends on rfbs_pkg for field widths

interface rfbs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rfbs_pkg::STAT_W-1:0]    status;
  logic [rfbs_pkg::PKT_W-1:0]     packet_out;
  logic [rfbs_pkg::IDX_W-1:0]     current_pointer;
  logic [rfbs_pkg::TOTAL_W-1:0]   packets_held;
  logic [rfbs_pkg::COUNT_W-1:0]   enqueue_total;
  logic [rfbs_pkg::COUNT_W-1:0]   dequeue_total;

  modport source (output valid, status, packet_out, current_pointer, packets_held,
                  enqueue_total, dequeue_total, input ready);
  modport sink (input valid, status, packet_out, current_pointer, packets_held,
                enqueue_total, dequeue_total, output ready);
endinterface

@@ hdl/rfbs_ctrl.sv @@
// rfbs_ctrl: request sequencing and output register occupancy
// depends on rfbs_pkg for the command struct

module rfbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output rfbs_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_full, out_full_next;
  logic   accept, load_out;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_ready && in_valid;
  assign load_out  = (state == S_RESP) && (!out_full || out_ready);
  assign out_valid = out_full;

  assign cmd.accept   = accept;
  assign cmd.load_out = load_out;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (load_out) out_full_next = 1'b1;
    else if (out_ready) out_full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RESP)
    else $error("accepted request did not move to response state");

  a_load_sets_full: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_full)
    else $error("result load did not fill output register");

  a_stall_holds_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_full && !out_ready) |=> state == S_RESP)
    else $error("pending result left response state while output stalled");
`endif

endmodule

@@ hdl/rfbs_datapath.sv @@
// rfbs_datapath: fifo bank storage, per-fifo pointers, rotating search and result register
// depends on rfbs_pkg for constants, codes and the command struct

module rfbs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rfbs_pkg::cmd_t                cmd,
  input  logic [rfbs_pkg::OP_W-1:0]     opcode,
  input  logic [rfbs_pkg::IDX_W-1:0]    fifo_index,
  input  logic [rfbs_pkg::PKT_W-1:0]    packet_handle,
  output logic [rfbs_pkg::STAT_W-1:0]   status,
  output logic [rfbs_pkg::PKT_W-1:0]    packet_out,
  output logic [rfbs_pkg::IDX_W-1:0]    current_pointer,
  output logic [rfbs_pkg::TOTAL_W-1:0]  packets_held,
  output logic [rfbs_pkg::COUNT_W-1:0]  enqueue_total,
  output logic [rfbs_pkg::COUNT_W-1:0]  dequeue_total
);

  localparam int NF  = rfbs_pkg::NUM_FIFOS;
  localparam int FD  = rfbs_pkg::FIFO_DEPTH;
  localparam int QW  = rfbs_pkg::Q_W;
  localparam int HW  = rfbs_pkg::HEAD_W;
  localparam int OW  = rfbs_pkg::OCC_W;
  localparam int AW  = rfbs_pkg::ADDR_W;
  localparam int PW  = rfbs_pkg::PKT_W;
  localparam int TW  = rfbs_pkg::TOTAL_W;
  localparam int CW  = rfbs_pkg::COUNT_W;

  logic [PW-1:0] mem [rfbs_pkg::MEM_DEPTH];
  logic [PW-1:0] mem_rdata;

  logic [HW-1:0] head [NF];
  logic [OW-1:0] occ  [NF];
  logic [QW-1:0] current;
  logic [TW-1:0] packet_total;
  logic [CW-1:0] enq_count;
  logic [CW-1:0] deq_count;

  logic [rfbs_pkg::STAT_W-1:0] res_status;
  logic                        res_from_mem;
  logic [PW-1:0]               res_pkt;

  logic [QW-1:0]   q;
  logic            idx_ok;
  logic [HW-1:0]   sel_head;
  logic [OW-1:0]   sel_occ;
  logic            sel_full;
  logic            sel_empty;
  logic [HW:0]     tail_sum;
  logic [HW-1:0]   tail;
  logic [HW:0]     head_sum;
  logic [HW-1:0]   head_inc;
  logic [NF-1:0]   nonempty;
  logic [2*NF-1:0] rot;
  logic            found;
  logic [QW-1:0]   offset;
  logic [QW:0]     pq_sum;
  logic [QW-1:0]   pq;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic            mem_re;
  logic            is_enq, is_deq, is_peek, is_set;

  assign is_enq  = (opcode == rfbs_pkg::OP_ENQ);
  assign is_deq  = (opcode == rfbs_pkg::OP_DEQ);
  assign is_peek = (opcode == rfbs_pkg::OP_PEEK);
  assign is_set  = (opcode == rfbs_pkg::OP_SETPTR);

  assign q         = QW'(fifo_index);
  assign idx_ok    = (32'(fifo_index) < 32'(NF));
  assign sel_head  = head[q];
  assign sel_occ   = occ[q];
  assign sel_full  = (sel_occ == OW'(FD));
  assign sel_empty = (sel_occ == '0);

  // write position wraps within the fifo
  assign tail_sum = (HW+1)'(sel_head) + (HW+1)'(sel_occ);
  assign tail     = (tail_sum >= (HW+1)'(FD)) ? HW'(tail_sum - (HW+1)'(FD)) : HW'(tail_sum);
  assign head_sum = (HW+1)'(sel_head) + (HW+1)'(1);
  assign head_inc = (head_sum >= (HW+1)'(FD)) ? '0 : HW'(head_sum);

  // rotating search for the first non-empty fifo at or after current
  always_comb begin
    for (int i = 0; i < NF; i++) nonempty[i] = (occ[i] != '0);
  end

  assign rot = {nonempty, nonempty} >> current;

  always_comb begin
    found  = 1'b0;
    offset = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (rot[i]) begin
        found  = 1'b1;
        offset = QW'(i);
      end
    end
  end

  assign pq_sum = (QW+1)'(current) + (QW+1)'(offset);
  assign pq     = (pq_sum >= (QW+1)'(NF)) ? QW'(pq_sum - (QW+1)'(NF)) : QW'(pq_sum);

  always_comb begin
    if (is_peek) mem_addr = AW'(pq) * AW'(FD) + AW'(head[pq]);
    else if (is_enq) mem_addr = AW'(q) * AW'(FD) + AW'(tail);
    else mem_addr = AW'(q) * AW'(FD) + AW'(sel_head);
  end

  assign mem_we = cmd.accept && is_enq && idx_ok && !sel_full;
  assign mem_re = cmd.accept && ((is_deq && idx_ok && !sel_empty) || (is_peek && found));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= packet_handle;
    if (mem_re) mem_rdata <= mem[mem_addr];
  end

  // bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NF; i++) begin
        head[i] <= '0;
        occ[i]  <= '0;
      end
      current      <= '0;
      packet_total <= '0;
      enq_count    <= '0;
      deq_count    <= '0;
    end else if (cmd.accept) begin
      if (is_enq && idx_ok && !sel_full) begin
        occ[q]       <= sel_occ + OW'(1);
        packet_total <= packet_total + TW'(1);
        enq_count    <= enq_count + CW'(1);
      end
      if (is_deq && idx_ok && !sel_empty) begin
        head[q]      <= head_inc;
        occ[q]       <= sel_occ - OW'(1);
        packet_total <= packet_total - TW'(1);
        deq_count    <= deq_count + CW'(1);
      end
      if (is_peek) current <= found ? pq : '0;
      if (is_set && idx_ok) current <= q;
    end
  end

  // per-request result, registered on accept alongside the storage read data
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status   <= rfbs_pkg::ST_OK;
      res_from_mem <= 1'b0;
      res_pkt      <= '0;
      case (opcode)
        rfbs_pkg::OP_ENQ: begin
          if (!idx_ok || sel_full) begin
            res_status <= rfbs_pkg::ST_DROP;
            res_pkt    <= packet_handle;
          end
        end
        rfbs_pkg::OP_DEQ: begin
          if (!idx_ok || sel_empty) res_status <= rfbs_pkg::ST_EMPTY;
          else res_from_mem <= 1'b1;
        end
        rfbs_pkg::OP_PEEK: begin
          if (!found) res_status <= rfbs_pkg::ST_EMPTY;
          else res_from_mem <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= res_status;
      packet_out      <= res_from_mem ? mem_rdata : res_pkt;
      current_pointer <= rfbs_pkg::IDX_W'(current);
      packets_held    <= packet_total;
      enqueue_total   <= enq_count;
      dequeue_total   <= deq_count;
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(packet_total) <= 32'(rfbs_pkg::MEM_DEPTH))
    else $error("packet total exceeds bank capacity");

  a_enq_counts: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> packet_total == $past(packet_total) + TW'(1))
    else $error("stored enqueue not counted in packet total");

  a_current_range: assert property (@(posedge clk) disable iff (rst)
    32'(current) < 32'(NF))
    else $error("current pointer beyond fifo count");
`endif

endmodule

@@ hdl/rotating_fifo_bank_scheduler.sv @@
// rotating_fifo_bank_scheduler: top level of the calendar queue fifo bank
// depends on rfbs_pkg, rfbs_req_if, rfbs_rsp_if, rfbs_ctrl and rfbs_datapath
//
// usage
//   request channel carries opcode, fifo_index and packet_handle: enqueue,
//   dequeue, peek earliest non-empty fifo from the current pointer, set pointer
//   result channel returns one item per request: status, handle, pointer,
//   packets held and the enqueue and dequeue totals
//   a request is taken when valid and ready are both high
//   each request is handled first in the accept cycle, which decodes it, runs the
//   rotating priority search and issues the single storage access, then in the
//   response state, which loads the result register from the registered storage
//   read once that register is empty or being drained; one request is in flight
//   at a time, so the next request is accepted only after that load; the result
//   is valid once loaded, and the output register lets the next request be
//   accepted while a result waits
//   when the receiver stalls, one result is held and one more request may be
//   processed, then request ready drops until the output register drains
//   synchronous reset empties every fifo, zeroes the pointer and all counters;
//   storage contents are not cleared and need no clearing pass

module rotating_fifo_bank_scheduler (
  input logic         clk,
  input logic         rst,
  rfbs_req_if.sink    request,
  rfbs_rsp_if.source  result
);

  rfbs_pkg::cmd_t cmd;

  rfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  rfbs_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (request.opcode),
    .fifo_index      (request.fifo_index),
    .packet_handle   (request.packet_handle),
    .status          (result.status),
    .packet_out      (result.packet_out),
    .current_pointer (result.current_pointer),
    .packets_held    (result.packets_held),
    .enqueue_total   (result.enqueue_total),
    .dequeue_total   (result.dequeue_total)
  );

endmodule
